>>> hdl/fqr_pkg.sv
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and codes for the run queue with removal by identifier.
// ----------------------------------------------------------------------------
package fqr_pkg;

  // Field widths
  localparam int unsigned ID_W = 16;
  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;

  // Default number of queue entries
  localparam int unsigned DEPTH_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REM = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Per-cell control: take the neighbour's entry, or load the new identifier
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> hdl/fqr_if.sv
// ----------------------------------------------------------------------------
// fqr_in_if / fqr_out_if
// Valid/ready channels carrying one queue command or one result item.
// ----------------------------------------------------------------------------
interface fqr_in_if;
  logic                     valid;
  logic                     ready;
  logic [fqr_pkg::OP_W-1:0] operation;
  logic [fqr_pkg::ID_W-1:0] thread_id;

  modport source (output valid, operation, thread_id, input ready);
  modport sink   (input valid, operation, thread_id, output ready);
endinterface

interface fqr_out_if;
  logic                     valid;
  logic                     ready;
  logic [fqr_pkg::ST_W-1:0] status;
  logic [fqr_pkg::ID_W-1:0] removed_id;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, status, removed_id, is_empty, is_full, input ready);
  modport sink   (input valid, status, removed_id, is_empty, is_full, output ready);
endinterface

>>> hdl/fqr_cell.sv
// ----------------------------------------------------------------------------
// fqr_cell
// One queue slot: occupancy flag and identifier, fed from the next slot.
// ----------------------------------------------------------------------------
module fqr_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fqr_pkg::cell_ctl_t       ctl,
  input  logic                     nb_valid,
  input  logic [fqr_pkg::ID_W-1:0] nb_id,
  input  logic [fqr_pkg::ID_W-1:0] load_id,
  output logic                     valid_o,
  output logic                     valid_nxt_o,
  output logic [fqr_pkg::ID_W-1:0] id_o
);
  import fqr_pkg::*;

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;

  // Next slot contents: shift in from the neighbour, load, or hold
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (ctl.shift) begin
      valid_nxt = nb_valid;
      id_nxt    = nb_id;
    end else if (ctl.load) begin
      valid_nxt = 1'b1;
      id_nxt    = load_id;
    end
  end

  // Occupancy is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Identifier payload, no reset
  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign valid_o     = valid_r;
  assign valid_nxt_o = valid_nxt;
  assign id_o        = id_r;

endmodule

>>> hdl/fqr_prefix.sv
// ----------------------------------------------------------------------------
// fqr_prefix
// Log-depth inclusive prefix OR over the hit vector, head first.
// ----------------------------------------------------------------------------
module fqr_prefix #(
  parameter int unsigned N = fqr_pkg::DEPTH_DEF
) (
  input  logic [N-1:0] hit,
  output logic [N-1:0] seen
);
  import fqr_pkg::*;

  localparam int unsigned LV = $clog2(N);

  logic [N-1:0] lvl [LV+1];

  assign lvl[0] = hit;

  // Each level folds in bits (1 << i) places nearer the head
  for (genvar i = 0; i < LV; i++) begin : g_lvl
    assign lvl[i+1] = lvl[i] | (lvl[i] << (1 << i));
  end

  assign seen = lvl[LV];

endmodule

>>> hdl/fifo_queue_with_remove_by_id_top.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_top
// Run queue of thread identifiers held in a row of slots, head in slot 0.
// Enqueue, dequeue and removal of the oldest matching identifier; removal
// closes the gap by shifting every later slot one place towards the head.
//
//   channel   direction  fields
//   in_ch     in         operation, thread_id
//   out_ch    out        status, removed_id, is_empty, is_full
//
// One item per cycle: all slots compare against the key at once and a
// log-depth prefix OR picks the oldest match, so each command completes in
// the cycle it is taken; its result sits in the output register from the
// next cycle. in_ch.ready falls only while a result waits and out_ch.ready
// is low. Synchronous active-low reset empties the queue.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id_top #(
  parameter int unsigned DEPTH = fqr_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fqr_in_if.sink    in_ch,
  fqr_out_if.source out_ch
);
  import fqr_pkg::*;

  logic            fire;
  logic            is_rm;
  logic [DEPTH-1:0] cell_valid, cell_valid_nxt, hit, seen, first;
  logic [ID_W-1:0] cell_id [DEPTH];
  cell_ctl_t       ctl [DEPTH];
  logic [ID_W-1:0] rid;
  logic [ST_W-1:0] status;

  logic            out_valid_r;
  logic [ST_W-1:0] status_r;
  logic [ID_W-1:0] removed_r;
  logic            empty_r, full_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign is_rm       = (in_ch.operation == OP_DEQ) || (in_ch.operation == OP_REM);

  // Hit vector: head slot for dequeue, matching slots for removal
  for (genvar k = 0; k < DEPTH; k++) begin : g_hit
    if (k == 0) begin : g_head
      assign hit[k] = cell_valid[k] &&
                      ((in_ch.operation == OP_DEQ) ||
                       ((in_ch.operation == OP_REM) && (cell_id[k] == in_ch.thread_id)));
    end else begin : g_body
      assign hit[k] = cell_valid[k] && (in_ch.operation == OP_REM) &&
                      (cell_id[k] == in_ch.thread_id);
    end
  end

  fqr_prefix #(.N(DEPTH)) u_prefix (
    .hit  (hit),
    .seen (seen)
  );

  assign first = seen & ~(seen << 1);

  // Row of slots
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic            nb_valid;
    logic [ID_W-1:0] nb_id;
    logic            prev_valid;

    if (k == DEPTH - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_id    = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[k+1];
      assign nb_id    = cell_id[k+1];
    end

    if (k == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cell_valid[k-1];
    end

    // Shift at and behind the removed slot; load the first free slot
    assign ctl[k].shift = fire && is_rm && seen[k];
    assign ctl[k].load  = fire && (in_ch.operation == OP_ENQ) &&
                          !cell_valid[k] && prev_valid;

    fqr_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl[k]),
      .nb_valid    (nb_valid),
      .nb_id       (nb_id),
      .load_id     (in_ch.thread_id),
      .valid_o     (cell_valid[k]),
      .valid_nxt_o (cell_valid_nxt[k]),
      .id_o        (cell_id[k])
    );
  end

  // Removed identifier: select the oldest hit, zero when none
  always_comb begin
    rid = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rid = rid | (cell_id[k] & {ID_W{first[k]}});
    end
  end

  // Status per command
  always_comb begin
    case (in_ch.operation)
      OP_ENQ:  status = cell_valid[DEPTH-1] ? ST_FULL : ST_OK;
      OP_DEQ,
      OP_REM:  status = seen[DEPTH-1] ? ST_OK : ST_MISS;
      default: status = ST_OK;
    endcase
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status;
      removed_r <= rid;
      empty_r   <= !cell_valid_nxt[0];
      full_r    <= cell_valid_nxt[DEPTH-1];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.removed_id = removed_r;
  assign out_ch.is_empty   = empty_r;
  assign out_ch.is_full    = full_r;

endmodule

>>> tb/sv/fifo_queue_with_remove_by_id_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_top_tb
// Self-checking bench for the run queue with removal by identifier. Commands
// go in through the valid/ready input channel in bursts with random gaps.
// The result channel stalls on a pattern of its own. Every accepted command
// is run through a behavioural copy of the queue, and each result item is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id_top_tb;
  import fqr_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;
  // Opcode outside the defined set: the queue is left as it is
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] removed_id;
    logic            is_empty;
    logic            is_full;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fqr_in_if  in_ch();
  fqr_out_if out_ch();

  fifo_queue_with_remove_by_id_top #(.DEPTH(QDEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioural queue contents, head at index 0, and results in flight
  logic [ID_W-1:0] run_queue[$];
  queue_result_t   pending_results[$];

  int unsigned error_count;
  int unsigned cmds_accepted;
  int unsigned results_seen;
  int unsigned full_rejects;
  int unsigned miss_count;
  int unsigned removals_by_id;
  int unsigned burst_left;

  // One line per mismatch, and a count
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Apply one command to the behavioural queue, return what it should give
  function automatic queue_result_t apply_command(input logic [OP_W-1:0] op,
                                                  input logic [ID_W-1:0] id);
    queue_result_t res;
    int hit;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    case (op)
      OP_ENQ: begin
        if (run_queue.size() >= QDEPTH) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          run_queue.push_back(id);
        end
      end
      OP_DEQ: begin
        if (run_queue.size() == 0) begin
          res.status = ST_MISS;
          miss_count++;
        end else begin
          res.removed_id = run_queue.pop_front();
        end
      end
      OP_REM: begin
        // oldest match wins
        for (int k = 0; k < run_queue.size(); k++) begin
          if (hit < 0 && run_queue[k] == id) hit = k;
        end
        if (hit < 0) begin
          res.status = ST_MISS;
          miss_count++;
        end else begin
          res.removed_id = run_queue[hit];
          run_queue.delete(hit);
          removals_by_id++;
        end
      end
      default: ;
    endcase
    res.is_empty = (run_queue.size() == 0);
    res.is_full  = (run_queue.size() >= QDEPTH);
    return res;
  endfunction

  // Result check first, then prediction of the command taken at this edge
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.status     = out_ch.status;
        got.removed_id = out_ch.removed_id;
        got.is_empty   = out_ch.is_empty;
        got.is_full    = out_ch.is_full;
        if (pending_results.size() == 0) begin
          report_mismatch("result item with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      got.status, want.status));
          if (got.removed_id !== want.removed_id)
            report_mismatch($sformatf("removed_id got %h exp %h",
                                      got.removed_id, want.removed_id));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b exp %b",
                                      got.is_empty, want.is_empty));
          if (got.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %b exp %b",
                                      got.is_full, want.is_full));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmds_accepted++;
        pending_results.push_back(apply_command(in_ch.operation, in_ch.thread_id));
      end
    end
  end

  // Result side back-pressure: always ready, random, or long on/off stretches
  int unsigned sink_mode;
  int unsigned sink_mode_left;
  int unsigned sink_hold;
  logic        sink_level;
  initial begin
    sink_mode      = 0;
    sink_mode_left = 0;
    sink_hold      = 0;
    sink_level     = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_mode_left == 0) begin
        sink_mode      = $urandom_range(0, 2);
        sink_mode_left = $urandom_range(30, 150);
      end else begin
        sink_mode_left--;
      end
      case (sink_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (sink_hold == 0) begin
            sink_hold  = $urandom_range(1, 8);
            sink_level = !sink_level;
          end
          sink_hold--;
          out_ch.ready <= sink_level;
        end
      endcase
    end
  end

  // Send one command; a new burst may start with a random gap
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.thread_id <= id;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Dequeue, removal and the undefined opcode on an empty queue
  task automatic test_empty_queue();
    send_cmd(OP_DEQ, 16'h0000);
    send_cmd(OP_REM, 16'hFFFF);
    send_cmd(OP_NOP, 16'h5A5A);
  endtask

  // Fill with extreme and duplicate identifiers, then push past full
  task automatic test_fill_and_overflow();
    send_cmd(OP_ENQ, 16'h0000);
    send_cmd(OP_ENQ, 16'hFFFF);
    send_cmd(OP_ENQ, 16'h1234);
    send_cmd(OP_ENQ, 16'h0042);
    send_cmd(OP_ENQ, 16'h1234);
    for (int k = 5; k < QDEPTH; k++) send_cmd(OP_ENQ, 16'h0100 + k[15:0]);
    send_cmd(OP_ENQ, 16'hBEEF);
    send_cmd(OP_NOP, 16'hFFFF);
  endtask

  // Removal of a duplicate, of the tail, of an absent id, then a dequeue
  task automatic test_remove_by_id();
    send_cmd(OP_REM, 16'h1234);
    send_cmd(OP_REM, 16'h0100 + QDEPTH[15:0] - 16'd1);
    send_cmd(OP_REM, 16'hDEAD);
    send_cmd(OP_DEQ, 16'hFFFF);
  endtask

  // Random traffic in fill, drain and balanced phases
  task automatic test_random_traffic(input int unsigned n_cmds);
    int unsigned bias;
    int unsigned roll;
    int unsigned qsize;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    bias = 0;
    for (int unsigned i = 0; i < n_cmds; i++) begin
      if (i % 40 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      // 0: mostly enqueue, 1: mostly dequeue/remove, 2: even mix
      case (bias)
        0: op = (roll < 65) ? OP_ENQ : (roll < 80) ? OP_DEQ : (roll < 97) ? OP_REM : OP_NOP;
        1: op = (roll < 25) ? OP_ENQ : (roll < 60) ? OP_DEQ : (roll < 97) ? OP_REM : OP_NOP;
        default:
           op = (roll < 45) ? OP_ENQ : (roll < 70) ? OP_DEQ : (roll < 97) ? OP_REM : OP_NOP;
      endcase
      // small pool gives duplicates and hits; full range toggles every bit
      if ($urandom_range(0, 4) == 0) id = 16'($urandom_range(0, 16'hFFFF));
      else                           id = 16'hA500 | 16'($urandom_range(0, 7));
      qsize = run_queue.size();
      if (op == OP_REM && qsize != 0 && $urandom_range(0, 9) < 6)
        id = run_queue[$urandom_range(0, qsize - 1)];
      send_cmd(op, id);
    end
  endtask

  // Overall limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned guard;
    error_count     = 0;
    cmds_accepted   = 0;
    results_seen    = 0;
    full_rejects    = 0;
    miss_count      = 0;
    removals_by_id  = 0;
    burst_left      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_ENQ;
    in_ch.thread_id <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_remove_by_id();
    test_random_traffic(925);
    in_ch.valid <= 1'b0;

    // Drain, then wait for any stray result
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Covered %0d commands and %0d results: %0d enqueues refused when full,",
             cmds_accepted, results_seen, full_rejects);
    $display("%0d empty or not-found misses, %0d removals by identifier.",
             miss_count, removals_by_id);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
